>>> rtl/core/orf_pkg.sv
// Shared types and constants for the overwriting ring FIFO.
package orf_pkg;

	localparam int DEPTH         = 16;
	localparam int PAYLOAD_WIDTH = 64;
	localparam int RESULT_CAP    = 16;

	localparam int ACTION_W = 3;
	localparam int WORD_W   = 64;
	localparam int LIMIT_W  = 5;
	localparam int FILL_W   = 5;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	localparam logic [ACTION_W-1:0] ACT_ENQ    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_DEQ    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DRAIN  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_STATUS = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [WORD_W-1:0]   payload_in;
		logic [LIMIT_W-1:0]  drain_limit;
	} cmd_t;

	typedef struct packed {
		logic               ok;
		logic [WORD_W-1:0]  payload_out;
		logic               overwrote;
		logic [FILL_W-1:0]  fill_count;
		logic               is_full;
		logic               is_empty;
		logic               last;
	} result_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic             shift;
		logic [DEPTH-1:0] load;
	} chain_ctl_t;

endpackage

>>> rtl/core/orf_cell.sv
// One storage cell of the FIFO chain: loads a new word or takes its neighbor's word.
module orf_cell (
	input  logic                              clk,
	input  orf_pkg::cell_ctl_t                ctl,
	input  logic [orf_pkg::PAYLOAD_WIDTH-1:0] new_word,
	input  logic [orf_pkg::PAYLOAD_WIDTH-1:0] next_word,
	output logic [orf_pkg::PAYLOAD_WIDTH-1:0] word
);

	logic [orf_pkg::PAYLOAD_WIDTH-1:0] word_q;

	// A load wins over the shift, so a full enqueue lands in the last cell.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= new_word;
		end else if (ctl.shift) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;

endmodule

>>> rtl/core/orf_ctrl.sv
// Command decoder, fill counter, drain sequencer and result register of the FIFO.
module orf_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  orf_pkg::cmd_t                     cmd,
	input  logic [orf_pkg::PAYLOAD_WIDTH-1:0] head_word,
	output orf_pkg::chain_ctl_t               chain,
	output logic                              busy,
	output logic                              done,
	output orf_pkg::result_t                  result
);

	orf_pkg::state_t                state_q, state_d;
	logic [orf_pkg::CNT_W-1:0]      count_q, count_d;
	logic [orf_pkg::CNT_W-1:0]      rem_q, rem_d;
	logic [orf_pkg::CMP_W-1:0]      limit_c, count_c, cap_c, n_c;
	logic                           accept, full, empty;
	logic                           emit, ok_d, ovw_d, last_d, sel_head;
	orf_pkg::result_t               res_q;
	logic                           done_q;

	assign accept = start && (state_q == orf_pkg::ST_IDLE);
	assign full   = (count_q == orf_pkg::CNT_W'(orf_pkg::DEPTH));
	assign empty  = (count_q == '0);

	// Entries a drain will pop: the smallest of limit, cap and fill count.
	assign limit_c = orf_pkg::CMP_W'(cmd.drain_limit);
	assign count_c = orf_pkg::CMP_W'(count_q);
	assign cap_c   = orf_pkg::CMP_W'(orf_pkg::RESULT_CAP);
	always_comb begin
		n_c = limit_c;
		if (n_c > cap_c) begin
			n_c = cap_c;
		end
		if (n_c > count_c) begin
			n_c = count_c;
		end
	end

	// Next state of the drain sequencer.
	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		unique case (state_q)
			orf_pkg::ST_IDLE: begin
				if (accept && (cmd.action == orf_pkg::ACT_DRAIN) &&
				    (n_c > orf_pkg::CMP_W'(1))) begin
					state_d = orf_pkg::ST_DRAIN;
					rem_d   = orf_pkg::CNT_W'(n_c - orf_pkg::CMP_W'(1));
				end
			end
			orf_pkg::ST_DRAIN: begin
				rem_d = rem_q - orf_pkg::CNT_W'(1);
				if (rem_q == orf_pkg::CNT_W'(1)) begin
					state_d = orf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = orf_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs: chain control, new fill count and the result fields.
	always_comb begin
		chain.shift = 1'b0;
		chain.load  = '0;
		count_d     = count_q;
		emit        = 1'b0;
		ok_d        = 1'b0;
		ovw_d       = 1'b0;
		last_d      = 1'b1;
		sel_head    = 1'b0;
		unique case (state_q)
			orf_pkg::ST_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					unique case (cmd.action)
						orf_pkg::ACT_ENQ: begin
							ok_d        = 1'b1;
							ovw_d       = full;
							chain.shift = full;
							for (int i = 0; i < orf_pkg::DEPTH; i++) begin
								chain.load[i] = full ? (i == orf_pkg::DEPTH - 1)
								                     : (count_q == orf_pkg::CNT_W'(i));
							end
							if (!full) begin
								count_d = count_q + orf_pkg::CNT_W'(1);
							end
						end
						orf_pkg::ACT_DEQ: begin
							if (!empty) begin
								ok_d        = 1'b1;
								sel_head    = 1'b1;
								chain.shift = 1'b1;
								count_d     = count_q - orf_pkg::CNT_W'(1);
							end
						end
						orf_pkg::ACT_PEEK: begin
							ok_d     = !empty;
							sel_head = !empty;
						end
						orf_pkg::ACT_DRAIN: begin
							if (n_c != '0) begin
								ok_d        = 1'b1;
								sel_head    = 1'b1;
								chain.shift = 1'b1;
								count_d     = count_q - orf_pkg::CNT_W'(1);
								last_d      = (n_c == orf_pkg::CMP_W'(1));
							end
						end
						orf_pkg::ACT_STATUS: begin
							ok_d = 1'b1;
						end
						default: begin
							ok_d = 1'b0;
						end
					endcase
				end
			end
			orf_pkg::ST_DRAIN: begin
				emit        = 1'b1;
				ok_d        = 1'b1;
				sel_head    = 1'b1;
				chain.shift = 1'b1;
				count_d     = count_q - orf_pkg::CNT_W'(1);
				last_d      = (rem_q == orf_pkg::CNT_W'(1));
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= orf_pkg::ST_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.ok          <= ok_d;
			res_q.payload_out <= sel_head ? orf_pkg::WORD_W'(head_word) : '0;
			res_q.overwrote   <= ovw_d;
			res_q.fill_count  <= orf_pkg::FILL_W'(count_d);
			res_q.is_full     <= (count_d == orf_pkg::CNT_W'(orf_pkg::DEPTH));
			res_q.is_empty    <= (count_d == '0);
			res_q.last        <= last_d;
		end
	end

	assign busy   = (state_q == orf_pkg::ST_DRAIN);
	assign done   = done_q;
	assign result = res_q;

endmodule

>>> rtl/core/overwriting_ring_fifo_top.sv
// Top level of the overwriting ring FIFO: controller plus a chain of storage cells.
// A result appears on result, marked by done, in the cycle after the command is accepted.
// Enqueue, dequeue, peek and status each give one result; one word per cycle while busy is low.
// A drain that pops n entries gives n results, with busy high while any but the last is shown;
// the chain pops exactly one entry per cycle by shifting every cell toward the head.
// Reset clears the fill count, the drain sequencer and done; the cells hold no reset value.
module overwriting_ring_fifo_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  orf_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done,
	output orf_pkg::result_t result
);

	// The oldest entry always sits in cell 0, the next oldest in cell 1, and so on.
	// A pop shifts every cell down by one; an enqueue writes the cell just past the
	// newest entry, or, on a full queue, shifts and writes the last cell, which drops
	// the oldest word without any head or tail pointer.
	orf_pkg::chain_ctl_t               chain;
	logic [orf_pkg::PAYLOAD_WIDTH-1:0] cell_word [orf_pkg::DEPTH];
	logic [orf_pkg::PAYLOAD_WIDTH-1:0] new_word;

	// Only the stored width of the payload is kept.
	assign new_word = cmd.payload_in[orf_pkg::PAYLOAD_WIDTH-1:0];

	orf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.head_word (cell_word[0]),
		.chain     (chain),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

	// Each cell takes its upper neighbor's word on a shift; the last cell takes zero,
	// which is never read before it is written again.
	for (genvar i = 0; i < orf_pkg::DEPTH; i++) begin : g_cell
		orf_pkg::cell_ctl_t                cctl;
		logic [orf_pkg::PAYLOAD_WIDTH-1:0] next_word;

		assign cctl.shift = chain.shift;
		assign cctl.load  = chain.load[i];

		if (i == orf_pkg::DEPTH - 1) begin : g_end
			assign next_word = '0;
		end else begin : g_mid
			assign next_word = cell_word[i + 1];
		end

		orf_cell u_cell (
			.clk       (clk),
			.ctl       (cctl),
			.new_word  (new_word),
			.next_word (next_word),
			.word      (cell_word[i])
		);
	end

	// While a drain runs, a result follows in every cycle.
	a_drain_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("drain cycle without a result");

	// A result that is not the last one of its command means the drain still runs.
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.last) |-> busy)
		else $error("non-final result outside a drain");

	// The end of a drain shows its final result.
	a_drain_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done && result.last))
		else $error("drain ended without a final result");

	// Full and empty never hold together.
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_full && result.is_empty))
		else $error("full and empty flagged together");

endmodule
